FILE: src/fpba_pkg.sv
package fpba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;

  localparam int IN_IDX_W   = 4;
  localparam int AMT_W      = 16;
  localparam int OUT_IDX_W  = 4;
  localparam int POL_W      = 2;
  localparam int NB_W       = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 2'd1;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic                 granted;
    logic [OUT_IDX_W-1:0] block;
  } res_t;

endpackage

FILE: src/fit_policy_block_allocator.sv
// Load words produce no result; the block is ready again next cycle.
// A request word is scanned one table entry per cycle; first fit can end the scan early.
// Its result then waits in the done state until the output register is free, and is
// registered there, where it waits until out_tready.
// Input is not ready while a request is scanned or waits in the done state.
// Synchronous active-low reset clears the capacity table, fit_policy to 0, num_blocks to 16.
module fit_policy_block_allocator
  import fpba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // [3:0] block_index, [19:4] amount, rest zero
  input  logic                  in_tuser,   // [0] opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [0] granted, [4:1] chosen_block, rest zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [POL_W-1:0]     fit_policy_r;
  logic [NB_W-1:0]      num_blocks_r;
  logic                 out_valid_r;
  res_t                 out_res_r;
  logic                 out_free;
  logic                 res_valid;
  res_t                 res;
  tbl_wr_t              tbl_wr;
  logic [IDX_W-1:0]     rd_idx;
  logic [SIZE_BITS-1:0] rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= POL_FIRST;
      num_blocks_r <= NB_W'(16);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIT_POLICY: fit_policy_r <= cfg_data[POL_W-1:0];
        CFG_NUM_BLOCKS: num_blocks_r <= cfg_data[NB_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_tready;

  fpba_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_opcode      (in_tuser),
    .in_block_index (in_tdata[3:0]),
    .in_amount      (in_tdata[19:4]),
    .fit_policy     (fit_policy_r),
    .num_blocks     (num_blocks_r),
    .out_free       (out_free),
    .res_valid      (res_valid),
    .res            (res),
    .tbl_wr         (tbl_wr),
    .rd_idx         (rd_idx),
    .rd_data        (rd_data)
  );

  fpba_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.block, out_res_r.granted};

  // A refused request always reports block zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[4:1] == 4'd0)
    else $error("refused request reports a nonzero block");

  // A load word never produces a result word.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_LOAD) |=> !$rose(out_tvalid))
    else $error("load word produced a result");

  // The scanner only hands over a result when the output register can take it.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> out_free && !in_tready)
    else $error("result issued while output busy or input open");

endmodule

FILE: src/fpba_table.sv
module fpba_table
  import fpba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  tbl_wr_t              wr,
  input  logic [IDX_W-1:0]     rd_idx,
  output logic [SIZE_BITS-1:0] rd_data
);

  logic [SIZE_BITS-1:0] cap_r [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        cap_r[i] <= '0;
      end
    end else if (wr.en) begin
      cap_r[wr.idx] <= wr.data;
    end
  end

  assign rd_data = cap_r[rd_idx];

endmodule

FILE: src/fpba_scan.sv
module fpba_scan
  import fpba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [IN_IDX_W-1:0]  in_block_index,
  input  logic [AMT_W-1:0]     in_amount,
  input  logic [POL_W-1:0]     fit_policy,
  input  logic [NB_W-1:0]      num_blocks,
  input  logic                 out_free,
  output logic                 res_valid,
  output res_t                 res,
  output tbl_wr_t              tbl_wr,
  output logic [IDX_W-1:0]     rd_idx,
  input  logic [SIZE_BITS-1:0] rd_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     limit_r, limit_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] held_r, held_nxt;
  logic [SIZE_BITS-1:0] amt_r, amt_nxt;

  logic fits;
  logic better;
  logic first_pol;
  logic idx_ok;

  assign rd_idx    = cnt_r[IDX_W-1:0];
  assign fits      = rd_data >= amt_r;
  assign first_pol = (fit_policy != POL_BEST) && (fit_policy != POL_WORST);
  assign idx_ok    = {1'b0, in_block_index} < (IN_IDX_W+1)'(MAX_BLOCKS);

  always_comb begin
    case (fit_policy)
      POL_BEST:  better = rd_data < held_r;
      POL_WORST: better = rd_data > held_r;
      default:   better = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    limit_nxt  = limit_r;
    found_nxt  = found_r;
    pick_nxt   = pick_r;
    held_nxt   = held_r;
    amt_nxt    = amt_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    tbl_wr.en   = 1'b0;
    tbl_wr.idx  = in_block_index[IDX_W-1:0];
    tbl_wr.data = SIZE_BITS'(in_amount);
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_LOAD) begin
            tbl_wr.en = idx_ok;
          end else begin
            amt_nxt   = SIZE_BITS'(in_amount);
            cnt_nxt   = '0;
            found_nxt = 1'b0;
            pick_nxt  = '0;
            held_nxt  = '0;
            limit_nxt = ({1'b0, num_blocks} > (NB_W+1)'(MAX_BLOCKS)) ?
                        CNT_W'(MAX_BLOCKS) : CNT_W'(num_blocks);
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r >= limit_r) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          if (fits && (!found_r || better)) begin
            found_nxt = 1'b1;
            pick_nxt  = cnt_r[IDX_W-1:0];
            held_nxt  = rd_data;
            // First fit stops at the first entry that is large enough.
            if (!found_r && first_pol) begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_valid   = 1'b1;
          tbl_wr.en   = found_r;
          tbl_wr.idx  = pick_r;
          tbl_wr.data = held_r - amt_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.granted = found_r;
  assign res.block   = found_r ? OUT_IDX_W'(pick_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      found_r <= 1'b0;
      cnt_r   <= '0;
      limit_r <= '0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      cnt_r   <= cnt_nxt;
      limit_r <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pick_r <= pick_nxt;
    held_r <= held_nxt;
    amt_r  <= amt_nxt;
  end

endmodule
